// ----- src/mmcs_pkg.sv -----
// ----------------------------------------------------------------------------
// mmcs_pkg
// Types and constants shared by the min/max contrast stretch unit.
// ----------------------------------------------------------------------------
package mmcs_pkg;

  localparam int unsigned FIELD_W  = 16;  // port width of sample and result
  localparam int unsigned LEVEL_W  = 16;  // width of max_level
  localparam int unsigned QUO_BITS = 16;  // quotient bits, one per divide step
  localparam int unsigned CNT_W    = $clog2(QUO_BITS);

  localparam logic CMD_MEASURE = 1'b0;
  localparam logic CMD_APPLY   = 1'b1;

  typedef struct packed {
    logic               command;
    logic [FIELD_W-1:0] sample;
    logic               last_sample;
  } in_word_t;

  typedef struct packed {
    logic [FIELD_W-1:0] stretched;
    logic               flat_range;
    logic               last_out;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULT,
    ST_PREP,
    ST_DIV,
    ST_WAIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic measure;   // fold accepted sample into min/max
    logic load;      // capture apply operands, clear tracker if last
    logic mult;      // register the scaled numerator
    logic prep;      // seed the divider
    logic step;      // one restoring divide step
    logic publish;   // move the result into the output register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;  // final divide step this cycle
    logic out_free;  // output register can take a word this cycle
  } dp_status_t;

endpackage

// ----- src/mmcs_ctrl.sv -----
// ----------------------------------------------------------------------------
// mmcs_ctrl
// Sequencer: accepts one word at a time and steps the datapath, for an apply
// word, through multiply, divider seed, sixteen divide steps and result hand-off.
// ----------------------------------------------------------------------------
module mmcs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_command,
  output logic                in_stall,
  input  mmcs_pkg::dp_status_t status,
  output mmcs_pkg::dp_cmd_t    cmd
);

  mmcs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mmcs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      mmcs_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_command == mmcs_pkg::CMD_APPLY) begin
            cmd.load  = 1'b1;
            state_nxt = mmcs_pkg::ST_MULT;
          end else begin
            cmd.measure = 1'b1;
          end
        end
      end
      mmcs_pkg::ST_MULT: begin
        cmd.mult  = 1'b1;
        state_nxt = mmcs_pkg::ST_PREP;
      end
      mmcs_pkg::ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = mmcs_pkg::ST_DIV;
      end
      mmcs_pkg::ST_DIV: begin
        cmd.step = 1'b1;
        if (status.div_last) begin
          state_nxt = mmcs_pkg::ST_WAIT;
        end
      end
      mmcs_pkg::ST_WAIT: begin
        if (status.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = mmcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mmcs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- src/mmcs_datapath.sv -----
// ----------------------------------------------------------------------------
// mmcs_datapath
// Min/max tracker, operand capture, multiplier, radix-2 restoring divider
// and the output register.
// ----------------------------------------------------------------------------
module mmcs_datapath #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mmcs_pkg::in_word_t   in_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [mmcs_pkg::LEVEL_W-1:0] cfg_data,
  input  mmcs_pkg::dp_cmd_t    cmd,
  output mmcs_pkg::dp_status_t status,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mmcs_pkg::out_word_t  out_data
);

  localparam int unsigned PROD_W = SAMPLE_BITS + mmcs_pkg::LEVEL_W;

  logic [SAMPLE_BITS-1:0] sample;

  // tracker and configuration
  logic [mmcs_pkg::LEVEL_W-1:0] max_level_r;
  logic [SAMPLE_BITS-1:0]       low_r, high_r;
  logic                         started_r;

  // apply operands
  logic [SAMPLE_BITS-1:0] diff_r, range_r;
  logic                   flat_r, zero_r, sat_r, last_r;

  // multiplier and divider
  logic [PROD_W-1:0]             prod_r;
  logic [SAMPLE_BITS-1:0]        rem_r;
  logic [mmcs_pkg::QUO_BITS-1:0] num_lo_r;
  logic [mmcs_pkg::QUO_BITS-1:0] quo_r;
  logic [mmcs_pkg::CNT_W-1:0]    cnt_r;
  logic [SAMPLE_BITS:0]          rem_sh;
  logic [SAMPLE_BITS:0]          rem_sub;
  logic                          q_bit;

  // output register
  mmcs_pkg::out_word_t out_r, out_nxt;
  logic                out_valid_r;

  assign sample = in_data.sample[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_level_r <= mmcs_pkg::LEVEL_W'(255);
    end else if (cfg_valid && cfg_ready) begin
      max_level_r <= cfg_data;
    end
  end

  // running min/max; a last apply word clears it once its operands are taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r     <= '0;
      high_r    <= '0;
      started_r <= 1'b0;
    end else if (cmd.measure) begin
      started_r <= 1'b1;
      if (!started_r) begin
        low_r  <= sample;
        high_r <= sample;
      end else begin
        if (sample < low_r) begin
          low_r <= sample;
        end
        if (sample > high_r) begin
          high_r <= sample;
        end
      end
    end else if (cmd.load && in_data.last_sample) begin
      low_r     <= '0;
      high_r    <= '0;
      started_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      diff_r  <= sample - low_r;
      range_r <= high_r - low_r;
      flat_r  <= (high_r <= low_r);
      zero_r  <= (sample <= low_r);
      sat_r   <= (sample >= high_r);
      last_r  <= in_data.last_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      prod_r <= PROD_W'(diff_r) * PROD_W'(max_level_r);
    end
  end

  // below the maximum the quotient is under max_level, so the upper product
  // bits are already below the range and only 16 quotient bits remain
  assign rem_sh  = {rem_r, num_lo_r[mmcs_pkg::QUO_BITS-1]};
  assign rem_sub = rem_sh - {1'b0, range_r};
  assign q_bit   = (rem_sh >= {1'b0, range_r});

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      rem_r    <= prod_r[PROD_W-1:mmcs_pkg::QUO_BITS];
      num_lo_r <= prod_r[mmcs_pkg::QUO_BITS-1:0];
      quo_r    <= '0;
    end else if (cmd.step) begin
      rem_r    <= q_bit ? rem_sub[SAMPLE_BITS-1:0] : rem_sh[SAMPLE_BITS-1:0];
      num_lo_r <= {num_lo_r[mmcs_pkg::QUO_BITS-2:0], 1'b0};
      quo_r    <= {quo_r[mmcs_pkg::QUO_BITS-2:0], q_bit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.prep) begin
      cnt_r <= '0;
    end else if (cmd.step) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign status.div_last = (cnt_r == mmcs_pkg::CNT_W'(mmcs_pkg::QUO_BITS - 1));
  assign status.out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_nxt.flat_range = flat_r;
    out_nxt.last_out   = last_r;
    priority if (flat_r || zero_r) begin
      out_nxt.stretched = '0;
    end else if (sat_r) begin
      out_nxt.stretched = mmcs_pkg::FIELD_W'(max_level_r);
    end else begin
      out_nxt.stretched = mmcs_pkg::FIELD_W'(quo_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- src/min_max_contrast_stretch_unit.sv -----
// ----------------------------------------------------------------------------
// min_max_contrast_stretch_unit
// Two-pass linear contrast stretch: measure words track min/max, apply words
// give (sample - min) * max_level / (max - min), saturated to max_level.
//
//   channel | direction | handshake     | word
//   in_     | input     | valid / stall | mmcs_pkg::in_word_t
//   out_    | output    | valid / stall | mmcs_pkg::out_word_t
//   cfg_    | input     | valid / ready | max_level, 16 bit
//
// Measure words are taken back to back. An apply word holds off the next
// word until it has passed through capture, multiply, divider seed, 16
// steps of the radix-2 restoring divider and hand-off to the output register.
// The output register frees the controller while a word waits on out_stall.
// Reset is synchronous: max_level returns to 255 and min/max are cleared.
// ----------------------------------------------------------------------------
module min_max_contrast_stretch_unit #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mmcs_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mmcs_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [mmcs_pkg::LEVEL_W-1:0] cfg_data
);

  mmcs_pkg::dp_cmd_t    cmd;
  mmcs_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  mmcs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .in_stall   (in_stall),
    .status     (status),
    .cmd        (cmd)
  );

  mmcs_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for min_max_contrast_stretch_unit. A short table of
// directed words and level writes (extremes, flat range, out-of-range samples,
// tracker clears) is followed by random frames of measure and apply words.
// Every accepted word goes through a local min/max stretch predictor, and each
// output word is compared field by field with the oldest prediction. The
// input idles and the output stalls at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned SAMPLE_BITS   = 16;
  localparam int unsigned RANDOM_WORDS  = 900;
  localparam int unsigned PHASE_WORDS   = 150;
  localparam int unsigned SETTLE_CYCLES = 30;

  typedef enum logic {ROW_ITEM, ROW_LEVEL} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic        command;
    logic [15:0] value;       // sample, or max_level on a level row
    logic        last_mark;
    bit          typed;       // result typed in below
    logic [15:0] stretched;
    logic        flat_range;
  } stim_row_t;

  logic                         clk       = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         in_valid  = 1'b0;
  logic                         in_stall;
  mmcs_pkg::in_word_t           in_data   = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  mmcs_pkg::out_word_t          out_data;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [mmcs_pkg::LEVEL_W-1:0] cfg_data  = '0;

  // predictor state
  logic [15:0] full_scale;
  logic [15:0] lo_track;
  logic [15:0] hi_track;
  logic        track_open;

  mmcs_pkg::out_word_t stretch_due_q[$];
  stim_row_t           stim_q[$];
  int unsigned         mismatch_count = 0;
  int unsigned         words_sent     = 0;
  int unsigned         burst_left     = 0;
  int unsigned         stall_run      = 0;
  logic                stall_level    = 1'b0;

  min_max_contrast_stretch_unit #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic compute_stretch(input mmcs_pkg::in_word_t w, output bit gives,
                                 output mmcs_pkg::out_word_t res);
    logic [15:0] s;
    logic [31:0] scaled;
    logic [31:0] quo;
    s = w.sample & 16'((32'd1 << SAMPLE_BITS) - 32'd1);
    res = '0;
    gives = 1'b0;
    if (w.command == mmcs_pkg::CMD_MEASURE) begin
      // a last mark on a measure word changes nothing
      if (!track_open) begin
        lo_track = s;
        hi_track = s;
        track_open = 1'b1;
      end else begin
        if (s < lo_track) lo_track = s;
        if (s > hi_track) hi_track = s;
      end
    end else begin
      gives = 1'b1;
      res.last_out = w.last_sample;
      if (hi_track <= lo_track) begin
        res.flat_range = 1'b1;
      end else if (s > lo_track) begin
        scaled = (32'(s) - 32'(lo_track)) * 32'(full_scale);
        quo = scaled / (32'(hi_track) - 32'(lo_track));
        if (quo > 32'(full_scale)) quo = 32'(full_scale);
        res.stretched = quo[15:0];
      end
      if (w.last_sample) begin
        lo_track = '0;
        hi_track = '0;
        track_open = 1'b0;
      end
    end
  endtask

  // drive one word, wait for it to be taken, then maybe leave a gap
  task automatic push_word(input mmcs_pkg::in_word_t w, input bit typed,
                           input mmcs_pkg::out_word_t typed_res);
    bit gives;
    mmcs_pkg::out_word_t res;
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    compute_stretch(w, gives, res);
    if (gives) stretch_due_q.push_back(typed ? typed_res : res);
    words_sent++;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // hold off until every predicted word has come back and the unit is quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (stretch_due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_level(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    full_scale = v;
  endtask

  function automatic logic [15:0] measure_sample(input int unsigned floor_v,
                                                 input int unsigned ceil_v);
    case ($urandom_range(0, 31))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(ceil_v, floor_v));
    endcase
  endfunction

  function automatic logic [15:0] apply_sample(input int unsigned floor_v,
                                               input int unsigned ceil_v);
    case ($urandom_range(0, 9))
      0, 1:    return 16'($urandom);
      2:       return 16'(floor_v);
      3:       return 16'(ceil_v);
      default: return 16'($urandom_range(ceil_v, floor_v));
    endcase
  endfunction

  task automatic run_frame();
    int unsigned        floor_v;
    int unsigned        ceil_v;
    int unsigned        shape;
    int unsigned        n_meas;
    int unsigned        n_apply;
    mmcs_pkg::in_word_t w;
    floor_v = $urandom_range(0, 65535);
    case ($urandom_range(0, 3))
      0: ceil_v = floor_v;
      1: begin
        ceil_v = floor_v + $urandom_range(1, 16);
        if (ceil_v > 65535) ceil_v = 65535;
      end
      default: ceil_v = $urandom_range(65535, floor_v);
    endcase
    shape = $urandom_range(0, 9);
    if (shape == 0) begin
      // noise: anything goes
      repeat ($urandom_range(1, 6)) begin
        w.command = 1'($urandom_range(0, 1));
        w.sample = 16'($urandom);
        w.last_sample = 1'($urandom_range(0, 1));
        push_word(w, 1'b0, '0);
      end
    end else begin
      // shape 1 applies with nothing measured, shape 2 leaves the frame open
      n_meas = (shape == 1) ? 0 : $urandom_range(1, 10);
      for (int unsigned i = 0; i < n_meas; i++) begin
        w.command = mmcs_pkg::CMD_MEASURE;
        w.sample = measure_sample(floor_v, ceil_v);
        w.last_sample = (i == n_meas - 1) ? 1'($urandom_range(0, 1))
                                          : 1'($urandom_range(0, 15) == 0);
        push_word(w, 1'b0, '0);
      end
      n_apply = $urandom_range(1, 10);
      for (int unsigned i = 0; i < n_apply; i++) begin
        w.command = mmcs_pkg::CMD_APPLY;
        w.sample = apply_sample(floor_v, ceil_v);
        w.last_sample = (i == n_apply - 1) && (shape != 2);
        push_word(w, 1'b0, '0);
      end
    end
  endtask

  // output side: compare each taken word with the oldest prediction
  always @(posedge clk) begin
    mmcs_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (stretch_due_q.size() == 0) begin
        $error("unexpected word: stretched %0d flat_range %0b last_out %0b",
               out_data.stretched, out_data.flat_range, out_data.last_out);
        mismatch_count++;
      end else begin
        want = stretch_due_q.pop_front();
        if (out_data.stretched !== want.stretched) begin
          $error("stretched: expected %0d, actual %0d", want.stretched, out_data.stretched);
          mismatch_count++;
        end
        if (out_data.flat_range !== want.flat_range) begin
          $error("flat_range: expected %0b, actual %0b", want.flat_range, out_data.flat_range);
          mismatch_count++;
        end
        if (out_data.last_out !== want.last_out) begin
          $error("last_out: expected %0b, actual %0b", want.last_out, out_data.last_out);
          mismatch_count++;
        end
      end
    end
  end

  // receiver stall pattern: clear stretches, long stalls and short flicker
  always @(posedge clk) begin
    if (stall_run == 0) begin
      case ($urandom_range(0, 7))
        0: begin
          stall_level = 1'b0;
          stall_run = $urandom_range(30, 80);
        end
        1, 2: begin
          stall_level = 1'b1;
          stall_run = $urandom_range(1, 12);
        end
        default: begin
          stall_level = 1'($urandom_range(0, 1));
          stall_run = $urandom_range(1, 4);
        end
      endcase
    end else begin
      stall_run--;
    end
    out_stall <= stall_level;
  end

  initial begin
    mmcs_pkg::in_word_t  w;
    mmcs_pkg::out_word_t res;
    int unsigned         table_words;
    int unsigned         next_phase;
    logic [15:0]         level;

    full_scale = 16'd255;
    lo_track = '0;
    hi_track = '0;
    track_open = 1'b0;

    // apply before anything is measured is the flat case
    stim_q.push_back('{ROW_ITEM, mmcs_pkg::CMD_APPLY, 16'd1234, 1'b0, 1'b1, 16'd0, 1'b1});
    // last mark on a measure word is ignored
    stim_q.push_back('{ROW_ITEM, mmcs_pkg::CMD_MEASURE, 16'd100, 1'b1, 1'b0, 16'd0, 1'b0});
    stim_q.push_back('{ROW_ITEM, mmcs_pkg::CMD_APPLY, 16'd100, 1'b0, 1'b1, 16'd0, 1'b1});
    stim_q.push_back('{ROW_ITEM, mmcs_pkg::CMD_MEASURE, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0});
    stim_q.push_back('{ROW_ITEM, mmcs_pkg::CMD_MEASURE, 16'd65535, 1'b0, 1'b0, 16'd0, 1'b0});
    stim_q.push_back('{ROW_ITEM, mmcs_pkg::CMD_APPLY, 16'd0, 1'b0, 1'b1, 16'd0, 1'b0});
    stim_q.push_back('{ROW_ITEM, mmcs_pkg::CMD_APPLY, 16'd65535, 1'b0, 1'b1, 16'd255, 1'b0});
    stim_q.push_back('{ROW_ITEM, mmcs_pkg::CMD_APPLY, 16'd32768, 1'b0, 1'b0, 16'd0, 1'b0});
    stim_q.push_back('{ROW_ITEM, mmcs_pkg::CMD_APPLY, 16'd65535, 1'b1, 1'b1, 16'd255, 1'b0});
    // tracker cleared by the last apply
    stim_q.push_back('{ROW_ITEM, mmcs_pkg::CMD_APPLY, 16'd7, 1'b0, 1'b1, 16'd0, 1'b1});
    stim_q.push_back('{ROW_ITEM, mmcs_pkg::CMD_MEASURE, 16'd1000, 1'b0, 1'b0, 16'd0, 1'b0});
    stim_q.push_back('{ROW_ITEM, mmcs_pkg::CMD_MEASURE, 16'd2000, 1'b0, 1'b0, 16'd0, 1'b0});
    stim_q.push_back('{ROW_ITEM, mmcs_pkg::CMD_MEASURE, 16'd1500, 1'b1, 1'b0, 16'd0, 1'b0});
    // below the minimum, above the maximum (saturates), inside, at the maximum
    stim_q.push_back('{ROW_ITEM, mmcs_pkg::CMD_APPLY, 16'd999, 1'b0, 1'b1, 16'd0, 1'b0});
    stim_q.push_back('{ROW_ITEM, mmcs_pkg::CMD_APPLY, 16'd3000, 1'b0, 1'b1, 16'd255, 1'b0});
    stim_q.push_back('{ROW_ITEM, mmcs_pkg::CMD_APPLY, 16'd1500, 1'b0, 1'b0, 16'd0, 1'b0});
    stim_q.push_back('{ROW_ITEM, mmcs_pkg::CMD_APPLY, 16'd2000, 1'b1, 1'b1, 16'd255, 1'b0});
    stim_q.push_back('{ROW_LEVEL, mmcs_pkg::CMD_MEASURE, 16'd65535, 1'b0, 1'b0, 16'd0, 1'b0});
    stim_q.push_back('{ROW_ITEM, mmcs_pkg::CMD_MEASURE, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0});
    stim_q.push_back('{ROW_ITEM, mmcs_pkg::CMD_MEASURE, 16'd65535, 1'b0, 1'b0, 16'd0, 1'b0});
    stim_q.push_back('{ROW_ITEM, mmcs_pkg::CMD_APPLY, 16'd65535, 1'b0, 1'b1, 16'd65535, 1'b0});
    stim_q.push_back('{ROW_ITEM, mmcs_pkg::CMD_APPLY, 16'd1, 1'b0, 1'b1, 16'd1, 1'b0});
    stim_q.push_back('{ROW_ITEM, mmcs_pkg::CMD_APPLY, 16'd65534, 1'b1, 1'b1, 16'd65534, 1'b0});
    // zero full scale gives zero everywhere
    stim_q.push_back('{ROW_LEVEL, mmcs_pkg::CMD_MEASURE, 16'd0, 1'b0, 1'b0, 16'd0, 1'b0});
    stim_q.push_back('{ROW_ITEM, mmcs_pkg::CMD_MEASURE, 16'd5, 1'b0, 1'b0, 16'd0, 1'b0});
    stim_q.push_back('{ROW_ITEM, mmcs_pkg::CMD_MEASURE, 16'd10, 1'b0, 1'b0, 16'd0, 1'b0});
    stim_q.push_back('{ROW_ITEM, mmcs_pkg::CMD_APPLY, 16'd10, 1'b0, 1'b1, 16'd0, 1'b0});
    stim_q.push_back('{ROW_ITEM, mmcs_pkg::CMD_APPLY, 16'd7, 1'b1, 1'b1, 16'd0, 1'b0});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_q[i]) begin
      if (stim_q[i].kind == ROW_LEVEL) begin
        settle();
        write_level(stim_q[i].value);
      end else begin
        w.command = stim_q[i].command;
        w.sample = stim_q[i].value;
        w.last_sample = stim_q[i].last_mark;
        res.stretched = stim_q[i].stretched;
        res.flat_range = stim_q[i].flat_range;
        res.last_out = stim_q[i].last_mark;
        push_word(w, stim_q[i].typed, res);
      end
    end

    table_words = words_sent;
    next_phase = words_sent;
    while (words_sent < table_words + RANDOM_WORDS) begin
      if (words_sent >= next_phase) begin
        case ($urandom_range(0, 4))
          0:       level = 16'd1;
          1:       level = 16'd65535;
          2:       level = 16'd255;
          default: level = 16'($urandom_range(1, 65535));
        endcase
        settle();
        write_level(level);
        next_phase += PHASE_WORDS;
      end
      run_frame();
    end

    settle();
    if (mismatch_count == 0 && stretch_due_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
